@@ design/art_pkg.sv @@
// Shared types and constants for the acknowledgement retry tracker.
// No dependencies; every other design file refers to it by scoped names.
package art_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RES     = 16;
  localparam int SLOT_IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(MAX_RES + 1);

  localparam int ACTION_W    = 2;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;
  localparam int RETRY_W     = 8;
  localparam int TIMEOUT_W   = 16;
  localparam int EVENT_W     = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  // Action codes on the input word; the fourth code is unused.
  localparam logic [ACTION_W-1:0] ACT_SENT     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RECEIVED = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 4'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [RETRY_W-1:0]   LIMIT_RST   = 8'd3;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE        = 3'd0,
    EV_TRACKED     = 3'd1,
    EV_DROPPED     = 3'd2,
    EV_ACK_CLEARED = 3'd3,
    EV_ACK_UNKNOWN = 3'd4,
    EV_RESEND      = 3'd5,
    EV_GAVE_UP     = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_CLEAR,
    OP_TICK
  } op_t;

  // Token that walks the cell chain, one cell per advance.
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic [ID_W-1:0]       id;
    logic [TIME_W-1:0]     now;
    logic                  found;
    logic                  free_seen;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [CNT_W-1:0]      ev_cnt;
  } token_t;

  typedef struct packed {
    logic               valid;
    event_t             res;
    logic [ID_W-1:0]    id;
    logic [RETRY_W-1:0] retries;
  } emit_t;

  typedef struct packed {
    event_t             res;
    logic [ID_W-1:0]    id;
    logic [RETRY_W-1:0] retries;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
    logic [TIME_W-1:0]     now;
  } wr_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic [RETRY_W-1:0]   limit;
  } cfg_t;

endpackage

@@ design/art_in_if.sv @@
// Input channel of the retry tracker: valid/ready plus one item.
// Depends on art_pkg for field widths.
interface art_in_if;
  logic                          valid;
  logic                          ready;
  logic [art_pkg::ACTION_W-1:0]  action;
  logic [art_pkg::ID_W-1:0]      message_id;
  logic                          is_request;
  logic                          ack_required;

  modport source (output valid, action, message_id, is_request, ack_required, input ready);
  modport sink   (input valid, action, message_id, is_request, ack_required, output ready);
endinterface

@@ design/art_out_if.sv @@
// Result channel of the retry tracker: valid/ready plus one event word.
// Depends on art_pkg for field widths.
interface art_out_if;
  logic                         valid;
  logic                         ready;
  logic [art_pkg::EVENT_W-1:0]  event_res;
  logic [art_pkg::ID_W-1:0]     event_id;
  logic [art_pkg::RETRY_W-1:0]  retry_number;
  logic                         last;

  modport source (output valid, event_res, event_id, retry_number, last, input ready);
  modport sink   (input valid, event_res, event_id, retry_number, last, output ready);
endinterface

@@ design/art_cfg_if.sv @@
// Configuration write channel of the retry tracker: valid/ready, index, data.
// Depends on art_pkg for field widths.
interface art_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [art_pkg::CFG_IDX_W-1:0]  index;
  logic [art_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/art_cell.sv @@
// One table slot of the retry tracker chain: holds a slot and passes the token on.
// Depends on art_pkg.
module art_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [art_pkg::SLOT_IDX_W-1:0] cell_idx,
  input  art_pkg::cfg_t                  cfg,
  input  art_pkg::wr_t                   wr,
  input  art_pkg::token_t                tok_in,
  output art_pkg::token_t                tok_out,
  output art_pkg::emit_t                 emit,
  output logic                           slot_valid
);

  logic                          valid_r, valid_nxt;
  logic [art_pkg::ID_W-1:0]      id_r, id_nxt;
  logic [art_pkg::TIME_W-1:0]    time_r, time_nxt;
  logic [art_pkg::RETRY_W-1:0]   retries_r, retries_nxt;
  art_pkg::token_t               tok_r, tok_nxt;
  logic                          hit;
  logic                          due;
  logic [art_pkg::TIME_W-1:0]    age;

  assign hit = valid_r && (id_r == tok_in.id);
  assign age = tok_in.now - time_r;
  assign due = valid_r && (age > art_pkg::TIME_W'(cfg.timeout));

  always_comb begin
    tok_nxt     = tok_in;
    valid_nxt   = valid_r;
    id_nxt      = id_r;
    time_nxt    = time_r;
    retries_nxt = retries_r;
    emit        = '0;
    if (tok_in.valid) begin
      case (tok_in.op)
        art_pkg::OP_INSERT: begin
          if (hit) begin
            tok_nxt.found = 1'b1;
            time_nxt      = tok_in.now;
            retries_nxt   = '0;
          end else if (!valid_r && !tok_in.free_seen) begin
            tok_nxt.free_seen = 1'b1;
            tok_nxt.free_idx  = cell_idx;
          end
        end
        art_pkg::OP_CLEAR: begin
          if (hit) begin
            tok_nxt.found = 1'b1;
            valid_nxt     = 1'b0;
          end
        end
        art_pkg::OP_TICK: begin
          if (due && (tok_in.ev_cnt < art_pkg::CNT_W'(art_pkg::MAX_RES))) begin
            emit.valid     = 1'b1;
            emit.id        = id_r;
            emit.retries   = retries_r;
            tok_nxt.ev_cnt = tok_in.ev_cnt + 1'b1;
            if (retries_r < cfg.limit) begin
              emit.res    = art_pkg::EV_RESEND;
              time_nxt    = tok_in.now;
              retries_nxt = retries_r + 1'b1;
            end else begin
              emit.res  = art_pkg::EV_GAVE_UP;
              valid_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // Hold everything while the output side stalls.
    if (!adv) begin
      valid_nxt   = valid_r;
      time_nxt    = time_r;
      retries_nxt = retries_r;
      tok_nxt     = tok_r;
    end
    if (wr.en && (wr.idx == cell_idx)) begin
      valid_nxt   = 1'b1;
      id_nxt      = wr.id;
      time_nxt    = wr.now;
      retries_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    time_r    <= time_nxt;
    retries_r <= retries_nxt;
  end

  assign tok_out    = tok_r;
  assign slot_valid = valid_r;

endmodule

@@ design/art_ctrl.sv @@
// Front and back end of the retry tracker: config, clock, launch, result staging.
// Depends on art_pkg and the three channel interfaces.
module art_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  art_in_if.sink                     in_ch,
  art_out_if.source                  out_ch,
  art_cfg_if.sink                    cfg_ch,
  input  art_pkg::token_t            tail,
  input  art_pkg::emit_t             emit,
  output art_pkg::token_t            launch,
  output logic                       adv,
  output art_pkg::cfg_t              cfg,
  output art_pkg::wr_t               wr
);

  logic [art_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [art_pkg::RETRY_W-1:0]   limit_r;
  logic [art_pkg::TIME_W-1:0]    now_r, now_nxt;
  art_pkg::token_t               launch_r, launch_nxt;
  logic                          busy_r, busy_nxt;
  art_pkg::emit_t                held_r, held_nxt;
  logic                          out_valid_r;
  art_pkg::out_word_t            out_r;
  logic                          accept;
  logic                          cfg_wr;
  logic                          finish;
  logic                          push;
  art_pkg::out_word_t            push_word;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !busy_r;
  assign accept       = in_ch.valid && !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign finish       = adv && tail.valid;

  assign cfg.timeout = timeout_r;
  assign cfg.limit   = limit_r;
  assign launch      = launch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= art_pkg::TIMEOUT_RST;
      limit_r   <= art_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        art_pkg::REG_TIMEOUT: timeout_r <= cfg_ch.data;
        art_pkg::REG_LIMIT:   limit_r   <= cfg_ch.data[art_pkg::RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decode the item into a chain operation and launch it.
  always_comb begin
    now_nxt    = now_r;
    launch_nxt = launch_r;
    busy_nxt   = busy_r;
    if (adv) begin
      launch_nxt.valid = 1'b0;
    end
    if (finish) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt   = 1'b1;
      launch_nxt = '0;
      launch_nxt.valid = 1'b1;
      launch_nxt.id    = in_ch.message_id;
      launch_nxt.now   = now_r;
      launch_nxt.op    = art_pkg::OP_NONE;
      if (in_ch.action == art_pkg::ACT_SENT) begin
        if (in_ch.ack_required && in_ch.is_request) begin
          launch_nxt.op = art_pkg::OP_INSERT;
        end
      end else if (in_ch.action == art_pkg::ACT_RECEIVED) begin
        if (!in_ch.is_request) begin
          launch_nxt.op = art_pkg::OP_CLEAR;
        end
      end else if (in_ch.action == art_pkg::ACT_TICK) begin
        now_nxt        = now_r + 1'b1;
        launch_nxt.now = now_nxt;
        launch_nxt.op  = art_pkg::OP_TICK;
      end
    end
  end

  // Keep one tick event back so the final one can carry last.
  always_comb begin
    held_nxt  = held_r;
    push      = 1'b0;
    push_word = '0;
    wr        = '0;
    wr.idx    = tail.free_idx;
    wr.id     = tail.id;
    wr.now    = tail.now;
    if (adv && emit.valid) begin
      held_nxt = emit;
      if (held_r.valid) begin
        push              = 1'b1;
        push_word.res     = held_r.res;
        push_word.id      = held_r.id;
        push_word.retries = held_r.retries;
      end
    end
    if (finish) begin
      push           = 1'b1;
      push_word.last = 1'b1;
      push_word.id   = tail.id;
      held_nxt.valid = 1'b0;
      case (tail.op)
        art_pkg::OP_TICK: begin
          if (held_r.valid) begin
            push_word.res     = held_r.res;
            push_word.id      = held_r.id;
            push_word.retries = held_r.retries;
          end else begin
            push_word.res = art_pkg::EV_NONE;
            push_word.id  = '0;
          end
        end
        art_pkg::OP_INSERT: begin
          if (tail.found) begin
            push_word.res = art_pkg::EV_TRACKED;
          end else if (tail.free_seen) begin
            push_word.res = art_pkg::EV_TRACKED;
            wr.en         = 1'b1;
          end else begin
            push_word.res = art_pkg::EV_DROPPED;
          end
        end
        art_pkg::OP_CLEAR: begin
          push_word.res = tail.found ? art_pkg::EV_ACK_CLEARED : art_pkg::EV_ACK_UNKNOWN;
        end
        default: begin
          push_word.res = art_pkg::EV_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r          <= '0;
      busy_r         <= 1'b0;
      launch_r.valid <= 1'b0;
      held_r.valid   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      now_r    <= now_nxt;
      busy_r   <= busy_nxt;
      launch_r <= launch_nxt;
      held_r   <= held_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_word;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = out_r.res;
  assign out_ch.event_id     = out_r.id;
  assign out_ch.retry_number = out_r.retries;
  assign out_ch.last         = out_r.last;

endmodule

@@ design/ack_retry_tracker.sv @@
// Top level of the acknowledgement retry tracker: controller plus a row of slot cells.
// Depends on art_pkg, the channel interfaces, art_ctrl and art_cell.
//
// Usage:
//   in_ch takes one word per item: request sent, response received or a 1 ms tick.
//   out_ch returns one or more event words per item; the final one has last set.
//   cfg_ch writes the resend timeout (index 0) and retry limit (index 1); write
//   only while no item is in flight. cfg_ch.ready is always high.
// Timing:
//   Each item walks a chain of TABLE_DEPTH cells, one cell per cycle while out_ch
//   is not stalled; in_ch takes no new item until the token has left the last
//   cell and the item's final event has been staged.
//   Tick events come out as the token passes each due slot, in slot order.
// Reset:
//   rst_n clears all slots, the millisecond clock and the in-flight token, and
//   loads the timeout with 1000 and the retry limit with 3.
// Stalls:
//   While a result word waits on out_ch, the whole chain holds in place; no
//   event is lost or repeated.
module ack_retry_tracker (
  input  logic       clk,
  input  logic       rst_n,
  art_in_if.sink     in_ch,
  art_out_if.source  out_ch,
  art_cfg_if.sink    cfg_ch
);

  art_pkg::token_t                  chain [art_pkg::TABLE_DEPTH+1];
  art_pkg::emit_t                   emits [art_pkg::TABLE_DEPTH];
  logic [art_pkg::TABLE_DEPTH-1:0]  slot_vld;
  logic [art_pkg::TABLE_DEPTH:0]    tok_vld;
  art_pkg::emit_t                   emit_any;
  art_pkg::cfg_t                    cfg;
  art_pkg::wr_t                     wr;
  logic                             adv;

  art_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .tail   (chain[art_pkg::TABLE_DEPTH]),
    .emit   (emit_any),
    .launch (chain[0]),
    .adv    (adv),
    .cfg    (cfg),
    .wr     (wr)
  );

  for (genvar i = 0; i < art_pkg::TABLE_DEPTH; i++) begin : g_cell
    art_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .cell_idx   (art_pkg::SLOT_IDX_W'(i)),
      .cfg        (cfg),
      .wr         (wr),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1]),
      .emit       (emits[i]),
      .slot_valid (slot_vld[i])
    );
  end

  // Only the cell holding the token can raise emit, so an OR picks it.
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < art_pkg::TABLE_DEPTH; i++) begin
      emit_any = art_pkg::emit_t'(emit_any | emits[i]);
    end
  end

  always_comb begin
    for (int i = 0; i <= art_pkg::TABLE_DEPTH; i++) begin
      tok_vld[i] = chain[i].valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (tok_vld == '0))
    else $error("token in flight while input is ready");

  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !slot_vld[wr.idx])
    else $error("insert targets an occupied slot");

  a_emit_tick: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any.valid |-> (tok_vld[art_pkg::TABLE_DEPTH] == 1'b0))
    else $error("tick event raised while the token sits at the tail");
`endif

endmodule

@@ tb/sv/ack_retry_tracker_tb.sv @@
// Self-checking testbench for ack_retry_tracker: directed and random traffic against
// an in-bench table predictor, with random stalls on the input and result channels.
// Depends on art_pkg, art_in_if, art_out_if, art_cfg_if and the tracker RTL.
module ack_retry_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [art_pkg::ACTION_W-1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [art_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 4'hF;
  localparam int                            CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n;

  art_in_if  in_bus ();
  art_out_if out_bus ();
  art_cfg_if cfg_bus ();

  ack_retry_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #5 clk = ~clk;

  // Predicted table state and register copies.
  logic                          tbl_valid   [art_pkg::TABLE_DEPTH] = '{default: 1'b0};
  logic [art_pkg::ID_W-1:0]      tbl_id      [art_pkg::TABLE_DEPTH] = '{default: '0};
  logic [art_pkg::TIME_W-1:0]    tbl_sent    [art_pkg::TABLE_DEPTH] = '{default: '0};
  logic [art_pkg::RETRY_W-1:0]   tbl_retries [art_pkg::TABLE_DEPTH] = '{default: '0};
  logic [art_pkg::TIME_W-1:0]    clock_ms    = '0;
  logic [art_pkg::TIMEOUT_W-1:0] cfg_timeout = art_pkg::TIMEOUT_RST;
  logic [art_pkg::RETRY_W-1:0]   cfg_limit   = art_pkg::LIMIT_RST;

  art_pkg::out_word_t pending_events [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  bit                 idle_en     = 1'b1;
  int                 ready_hold  = 0;
  int unsigned        ready_gap;

  function automatic int find_slot(input logic [art_pkg::ID_W-1:0] id);
    for (int i = 0; i < art_pkg::TABLE_DEPTH; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_event(input art_pkg::event_t kind,
                                     input logic [art_pkg::ID_W-1:0] id,
                                     input logic [art_pkg::RETRY_W-1:0] retries);
    art_pkg::out_word_t evt;
    evt = '{res: kind, id: id, retries: retries, last: 1'b0};
    pending_events = {pending_events, evt};
  endfunction

  function automatic void predict_events(input logic [art_pkg::ACTION_W-1:0] action,
                                         input logic [art_pkg::ID_W-1:0] id,
                                         input logic is_req, input logic ack);
    int                         slot;
    int                         emitted;
    logic [art_pkg::TIME_W-1:0] age;
    art_pkg::out_word_t         tail;
    slot = -1;
    emitted = 0;
    case (action)
      art_pkg::ACT_SENT: begin
        if (ack && is_req) begin
          slot = find_slot(id);
          for (int i = 0; i < art_pkg::TABLE_DEPTH && slot < 0; i++)
            if (!tbl_valid[i]) slot = i;
          if (slot < 0) begin
            push_event(art_pkg::EV_DROPPED, id, '0);
          end else begin
            tbl_valid[slot]   = 1'b1;
            tbl_id[slot]      = id;
            tbl_sent[slot]    = clock_ms;
            tbl_retries[slot] = '0;
            push_event(art_pkg::EV_TRACKED, id, '0);
          end
        end else begin
          push_event(art_pkg::EV_NONE, id, '0);
        end
      end
      art_pkg::ACT_RECEIVED: begin
        if (!is_req) begin
          slot = find_slot(id);
          if (slot >= 0) begin
            tbl_valid[slot] = 1'b0;
            push_event(art_pkg::EV_ACK_CLEARED, id, '0);
          end else begin
            push_event(art_pkg::EV_ACK_UNKNOWN, id, '0);
          end
        end else begin
          push_event(art_pkg::EV_NONE, id, '0);
        end
      end
      art_pkg::ACT_TICK: begin
        clock_ms = clock_ms + 1'b1;
        for (int i = 0; i < art_pkg::TABLE_DEPTH && emitted < art_pkg::MAX_RES; i++) begin
          age = clock_ms - tbl_sent[i];
          if (tbl_valid[i] && age > {16'h0, cfg_timeout}) begin
            emitted++;
            if (tbl_retries[i] < cfg_limit) begin
              push_event(art_pkg::EV_RESEND, tbl_id[i], tbl_retries[i]);
              tbl_sent[i]    = clock_ms;
              tbl_retries[i] = tbl_retries[i] + 1'b1;
            end else begin
              push_event(art_pkg::EV_GAVE_UP, tbl_id[i], tbl_retries[i]);
              tbl_valid[i] = 1'b0;
            end
          end
        end
        if (emitted == 0) push_event(art_pkg::EV_NONE, '0, '0);
      end
      default: push_event(art_pkg::EV_NONE, id, '0);
    endcase
    // mark the final word of this item
    tail = pending_events[pending_events.size() - 1];
    tail.last = 1'b1;
    pending_events[pending_events.size() - 1] = tail;
  endfunction

  function automatic void check_event();
    art_pkg::out_word_t got;
    art_pkg::out_word_t want;
    got = '{res: art_pkg::event_t'(out_bus.event_res), id: out_bus.event_id,
            retries: out_bus.retry_number, last: out_bus.last};
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected event res=%0d id=%h retry=%0d last=%b", $time,
               got.res, got.id, got.retries, got.last);
      error_count++;
    end else begin
      want = pending_events.pop_front();
      if (got !== want) begin
        $display("%0t: event mismatch: expected res=%0d id=%h retry=%0d last=%b,",
                 $time, want.res, want.id, want.retries, want.last,
                 " got res=%0d id=%h retry=%0d last=%b",
                 got.res, got.id, got.retries, got.last);
        error_count++;
      end
    end
  endfunction

  // Monitor: register writes, accepted items and result words, in that order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          art_pkg::REG_TIMEOUT: cfg_timeout = cfg_bus.data;
          art_pkg::REG_LIMIT:   cfg_limit   = cfg_bus.data[art_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        predict_events(in_bus.action, in_bus.message_id, in_bus.is_request,
                       in_bus.ack_required);
      if (out_bus.valid && out_bus.ready) check_event();
    end
  end

  // Result side: maybe stall after a word, and wiggle ready while nothing is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      ready_gap = idle_en ? $urandom_range(0, 3) : 0;
      ready_hold <= ready_gap;
      out_bus.ready <= (ready_gap == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_bus.ready <= (ready_hold == 1);
    end else if (idle_en && !out_bus.valid) begin
      out_bus.ready <= 1'($urandom_range(0, 1));
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d events outstanding", $time,
               cycle_count, pending_events.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Leave valid high on return so back-to-back words need no second assignment.
  task automatic send_item(input logic [art_pkg::ACTION_W-1:0] action,
                           input logic [art_pkg::ID_W-1:0] id,
                           input logic is_req, input logic ack);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= action;
    in_bus.message_id   <= id;
    in_bus.is_request   <= is_req;
    in_bus.ack_required <= ack;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drop valid, wait for every predicted word, then let the cell chain empty.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (art_pkg::TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic set_config(input logic [art_pkg::TIMEOUT_W-1:0] timeout_ms,
                            input logic [art_pkg::RETRY_W-1:0] limit);
    logic [art_pkg::CFG_IDX_W-1:0]  idx [3];
    logic [art_pkg::CFG_DATA_W-1:0] val [3];
    idx = '{REG_UNUSED, art_pkg::REG_TIMEOUT, art_pkg::REG_LIMIT};
    val = '{16'($urandom), timeout_ms, {8'($urandom), limit}};
    for (int k = 0; k < 3; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= val[k];
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Reset registers: no-op words, unknown acks, track, refresh, clear.
  task automatic test_basic_actions();
    send_item(art_pkg::ACT_SENT, 16'h00A5, 1'b0, 1'b1);
    send_item(art_pkg::ACT_SENT, 16'h5A00, 1'b1, 1'b0);
    send_item(art_pkg::ACT_RECEIVED, 16'hFFFF, 1'b1, 1'b1);
    send_item(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1);
    send_item(art_pkg::ACT_RECEIVED, 16'h1234, 1'b0, 1'b0);
    send_item(art_pkg::ACT_SENT, 16'h0000, 1'b1, 1'b1);
    send_item(art_pkg::ACT_SENT, 16'hFFFF, 1'b1, 1'b1);
    send_item(art_pkg::ACT_SENT, 16'hFFFF, 1'b1, 1'b1);
    send_item(art_pkg::ACT_TICK, 16'hFFFF, 1'b1, 1'b1);
    send_item(art_pkg::ACT_RECEIVED, 16'h0000, 1'b0, 1'b1);
    send_item(art_pkg::ACT_RECEIVED, 16'h0000, 1'b0, 1'b0);
    send_item(art_pkg::ACT_RECEIVED, 16'hFFFF, 1'b0, 1'b0);
  endtask

  // Fill all slots, overflow once, then sweep a full table through resend and give-up.
  task automatic test_table_full();
    drain();
    set_config(16'd1, 8'd1);
    for (int i = 0; i < art_pkg::TABLE_DEPTH; i++)
      send_item(art_pkg::ACT_SENT, 16'(i) * 16'h1111 ^ 16'h8421, 1'b1, 1'b1);
    send_item(art_pkg::ACT_SENT, 16'hBEEF, 1'b1, 1'b1);
    send_item(art_pkg::ACT_SENT, 16'd5 * 16'h1111 ^ 16'h8421, 1'b1, 1'b1);
    repeat (4) send_item(art_pkg::ACT_TICK, '0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    logic [art_pkg::ID_W-1:0]      pool [24];
    logic [art_pkg::TIMEOUT_W-1:0] timeout_ms;
    logic [art_pkg::RETRY_W-1:0]   limit;
    int unsigned                   pick;
    logic [art_pkg::ID_W-1:0]      id;
    for (int p = 0; p < phases; p++) begin
      drain();
      timeout_ms = (p == 0) ? 16'hFFFF : (p == 1) ? 16'd1 : 16'($urandom_range(0, 6));
      limit      = (p == 0) ? 8'd0 : 8'($urandom_range(0, 4));
      set_config(timeout_ms, limit);
      idle_en = (p != 2);
      foreach (pool[k]) pool[k] = 16'($urandom);
      for (int n = 0; n < per_phase; n++) begin
        pick = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, 23)];
        if (pick < 40)
          send_item(art_pkg::ACT_SENT, id, $urandom_range(0, 9) != 0,
                    $urandom_range(0, 9) != 0);
        else if (pick < 65)
          send_item(art_pkg::ACT_RECEIVED, id, $urandom_range(0, 9) == 0, 1'($urandom));
        else if (pick < 94)
          send_item(art_pkg::ACT_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
        else
          send_item(ACT_UNUSED, 16'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    idle_en = 1'b1;
  endtask

  // Zero timeout with the largest limit: every tick resends until the count tops out.
  task automatic test_retry_saturation();
    drain();
    set_config(16'd0, 8'd255);
    idle_en = 1'b0;
    send_item(art_pkg::ACT_SENT, 16'($urandom), 1'b1, 1'b1);
    send_item(art_pkg::ACT_SENT, 16'($urandom), 1'b1, 1'b1);
    repeat (259) send_item(art_pkg::ACT_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.action        = art_pkg::ACT_SENT;
    in_bus.message_id    = '0;
    in_bus.is_request    = 1'b0;
    in_bus.ack_required  = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = art_pkg::REG_TIMEOUT;
    cfg_bus.data         = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_actions();
    test_table_full();
    test_random_traffic(5, 34);
    test_retry_saturation();
    drain();

    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected events never arrived", $time, pending_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
